>>> hdl/sct_pkg.sv
// Shared types, key masks and the token text table for the chord translator
package sct_pkg;

  // key bits of a chord, number bar in bit 0
  localparam logic [22:0] KEY_NUM  = 23'h000001;
  localparam logic [22:0] KEY_IS   = 23'h000002;
  localparam logic [22:0] KEY_IT   = 23'h000004;
  localparam logic [22:0] KEY_IK   = 23'h000008;
  localparam logic [22:0] KEY_IP   = 23'h000010;
  localparam logic [22:0] KEY_IW   = 23'h000020;
  localparam logic [22:0] KEY_IH   = 23'h000040;
  localparam logic [22:0] KEY_IR   = 23'h000080;
  localparam logic [22:0] KEY_VA   = 23'h000100;
  localparam logic [22:0] KEY_VO   = 23'h000200;
  localparam logic [22:0] KEY_STAR = 23'h000400;
  localparam logic [22:0] KEY_VE   = 23'h000800;
  localparam logic [22:0] KEY_VU   = 23'h001000;
  localparam logic [22:0] KEY_FF   = 23'h002000;
  localparam logic [22:0] KEY_FR   = 23'h004000;
  localparam logic [22:0] KEY_FP   = 23'h008000;
  localparam logic [22:0] KEY_FB   = 23'h010000;
  localparam logic [22:0] KEY_FL   = 23'h020000;
  localparam logic [22:0] KEY_FG   = 23'h040000;
  localparam logic [22:0] KEY_FT   = 23'h080000;
  localparam logic [22:0] KEY_FS   = 23'h100000;
  localparam logic [22:0] KEY_FD   = 23'h200000;
  localparam logic [22:0] KEY_FZ   = 23'h400000;

  // key groups
  localparam logic [22:0] MASK_INIT = KEY_STAR | KEY_IS | KEY_IT | KEY_IK | KEY_IP | KEY_IW
                                    | KEY_IH | KEY_IR;
  localparam logic [22:0] MASK_VOW  = KEY_VA | KEY_VO | KEY_VE | KEY_VU;
  localparam logic [22:0] MASK_FIN  = KEY_STAR | KEY_FF | KEY_FR | KEY_FP | KEY_FB | KEY_FL
                                    | KEY_FG | KEY_FT | KEY_FS | KEY_FD | KEY_FZ;

  // output slots of one chord, in emission order
  localparam int NUM_SLOTS = 26;
  localparam int TEXT_W    = 96;

  // token codes, each one fixed piece of text
  typedef enum logic [5:0] {
    TOK_NONE, TOK_COMMA, TOK_CORR, TOK_PARA, TOK_DOT, TOK_QUEST, TOK_NEWLINE,
    TOK_D0, TOK_D1, TOK_D2, TOK_D3, TOK_D4, TOK_D5, TOK_D6, TOK_D7, TOK_D8, TOK_D9,
    TOK_B, TOK_CH, TOK_D, TOK_F, TOK_G, TOK_J, TOK_L, TOK_M, TOK_N, TOK_QU, TOK_V,
    TOK_Y, TOK_Z, TOK_S, TOK_T, TOK_K, TOK_P, TOK_W, TOK_H, TOK_R,
    TOK_AY, TOK_AW, TOK_EE, TOK_I, TOK_IY, TOK_OH, TOK_OI, TOK_OO, TOK_OU, TOK_UU,
    TOK_A, TOK_O, TOK_STAR, TOK_E, TOK_U,
    TOK_MP, TOK_NG, TOK_RCH, TOK_RF, TOK_SH, TOK_X, TOK_SHUN, TOK_NK, TOK_KSHUN
  } tok_t;

  // classified chord as passed from front to back
  typedef struct packed {
    tok_t       whole;
    tok_t       init_combo;
    logic [6:0] init_keys;   // S T K P W H R from bit 0
    tok_t       vow_combo;
    logic [4:0] vow_keys;    // A O star E U from bit 0
    tok_t       fin_combo;
    logic [9:0] fin_keys;    // F R P B L G T S D Z from bit 0
  } sct_desc_t;

  // text of a token, first character in the highest used byte
  typedef struct packed {
    logic [3:0]        len;
    logic [TEXT_W-1:0] text;
  } tok_info_t;

  function automatic tok_info_t ti(input logic [3:0] len, input logic [TEXT_W-1:0] text);
    tok_info_t r;
    r.len  = len;
    r.text = text;
    return r;
  endfunction

  function automatic tok_info_t tok_text(input tok_t tok);
    tok_info_t r;
    unique case (tok)
      TOK_COMMA:   r = ti(4'd1, ",");
      TOK_CORR:    r = ti(4'd12, "[correction]");
      TOK_PARA:    r = ti(4'd11, "[paragraph]");
      TOK_DOT:     r = ti(4'd1, ".");
      TOK_QUEST:   r = ti(4'd1, "?");
      TOK_NEWLINE: r = ti(4'd9, "[newline]");
      TOK_D0:      r = ti(4'd1, "0");
      TOK_D1:      r = ti(4'd1, "1");
      TOK_D2:      r = ti(4'd1, "2");
      TOK_D3:      r = ti(4'd1, "3");
      TOK_D4:      r = ti(4'd1, "4");
      TOK_D5:      r = ti(4'd1, "5");
      TOK_D6:      r = ti(4'd1, "6");
      TOK_D7:      r = ti(4'd1, "7");
      TOK_D8:      r = ti(4'd1, "8");
      TOK_D9:      r = ti(4'd1, "9");
      TOK_B:       r = ti(4'd1, "B");
      TOK_CH:      r = ti(4'd2, "CH");
      TOK_D:       r = ti(4'd1, "D");
      TOK_F:       r = ti(4'd1, "F");
      TOK_G:       r = ti(4'd1, "G");
      TOK_J:       r = ti(4'd1, "J");
      TOK_L:       r = ti(4'd1, "L");
      TOK_M:       r = ti(4'd1, "M");
      TOK_N:       r = ti(4'd1, "N");
      TOK_QU:      r = ti(4'd2, "QU");
      TOK_V:       r = ti(4'd1, "V");
      TOK_Y:       r = ti(4'd1, "Y");
      TOK_Z:       r = ti(4'd1, "Z");
      TOK_S:       r = ti(4'd1, "S");
      TOK_T:       r = ti(4'd1, "T");
      TOK_K:       r = ti(4'd1, "K");
      TOK_P:       r = ti(4'd1, "P");
      TOK_W:       r = ti(4'd1, "W");
      TOK_H:       r = ti(4'd1, "H");
      TOK_R:       r = ti(4'd1, "R");
      TOK_AY:      r = ti(4'd2, "AY");
      TOK_AW:      r = ti(4'd2, "AW");
      TOK_EE:      r = ti(4'd2, "EE");
      TOK_I:       r = ti(4'd1, "I");
      TOK_IY:      r = ti(4'd2, "IY");
      TOK_OH:      r = ti(4'd2, "OH");
      TOK_OI:      r = ti(4'd2, "OI");
      TOK_OO:      r = ti(4'd2, "OO");
      TOK_OU:      r = ti(4'd2, "OU");
      TOK_UU:      r = ti(4'd2, "UU");
      TOK_A:       r = ti(4'd1, "A");
      TOK_O:       r = ti(4'd1, "O");
      TOK_STAR:    r = ti(4'd1, "*");
      TOK_E:       r = ti(4'd1, "E");
      TOK_U:       r = ti(4'd1, "U");
      TOK_MP:      r = ti(4'd2, "MP");
      TOK_NG:      r = ti(4'd2, "NG");
      TOK_RCH:     r = ti(4'd3, "RCH");
      TOK_RF:      r = ti(4'd2, "RF");
      TOK_SH:      r = ti(4'd2, "SH");
      TOK_X:       r = ti(4'd1, "X");
      TOK_SHUN:    r = ti(4'd4, "SHUN");
      TOK_NK:      r = ti(4'd2, "NK");
      TOK_KSHUN:   r = ti(4'd5, "KSHUN");
      default:     r = ti(4'd1, '0);
    endcase
    return r;
  endfunction

endpackage

>>> hdl/steno_chord_to_text.sv
// Top level of the stenotype chord to text translator
//
// One 23-bit chord comes in per transaction on the s_axis channel and is
// turned into its text, sent one ASCII character per transaction on the
// m_axis channel with tlast on the final character of that chord.
// A chord with no text gives a single transaction with character zero,
// tlast high and tuser high.
// The front classifies a chord in the cycle it is accepted and writes it
// into a short queue; the back takes chords from the queue and sends one
// character per cycle from its output register when the receiver is ready.
// The first character of a chord reaching an idle block passes through the
// queue entry, the back's chord register and the output register.
// A chord gives max(1, n) transactions, n being its character count (up to
// 20), all through the single-character output register; the back loads
// the next queued chord as it registers a chord's last character.
// Input is taken while the queue has room, also while the receiver stalls;
// a stall holds the output register and the back's position in its chord.
// Reset empties the queue and drops any chord in progress.
module steno_chord_to_text import sct_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // chord [22:0], zero [23]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // text_char [6:0], zero [7]
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // empty_res [0]
);

  sct_desc_t  front_desc;
  sct_desc_t  q_desc;
  logic       q_valid;
  logic       q_pop;
  logic [6:0] text_char;
  logic       empty_res;

  // classify
  sct_front u_front (
    .chord (s_axis_tdata[22:0]),
    .desc  (front_desc)
  );

  // decouple
  sct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_desc   (front_desc),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_desc  (q_desc)
  );

  // emit characters
  sct_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_desc  (q_desc),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_char  (text_char),
    .m_last  (m_axis_tlast),
    .m_empty (empty_res)
  );

  assign m_axis_tdata = {1'b0, text_char};
  assign m_axis_tuser = empty_res;

  // an empty translation is a single zero character that closes the chord
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'd0 && m_axis_tlast)
    else $error("empty result not a lone zero character");

  // the back only takes a chord that the queue holds
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // nothing leaves the block in the cycle after reset
  assert property (@(posedge clk) $past(rst) && !rst |-> !m_axis_tvalid)
    else $error("output valid straight after reset");

  // loading a chord while a stalled result waits leaves that result as it is
  assert property (@(posedge clk) disable iff (rst)
    q_pop && m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled character changed while loading a chord");

endmodule

>>> hdl/sct_front.sv
// Front part: classifies a chord into whole-chord, combination and single-key tokens
module sct_front import sct_pkg::*; (
  input  logic [22:0] chord,
  output sct_desc_t   desc
);

  tok_t        whole;
  tok_t        init_combo;
  tok_t        vow_combo;
  tok_t        fin_combo;
  logic [22:0] init_bits;
  logic [22:0] vow_bits;
  logic [22:0] fin_bits;
  logic        star_left;

  // whole-chord punctuation, commands and digits
  always_comb begin
    unique case (chord)
      KEY_FR | KEY_FB | KEY_FG | KEY_FS:          whole = TOK_COMMA;
      KEY_STAR:                                   whole = TOK_CORR;
      KEY_IP | KEY_FF:                            whole = TOK_PARA;
      KEY_FF | KEY_FP | KEY_FL | KEY_FT:          whole = TOK_DOT;
      KEY_IS | KEY_IT | KEY_IP | KEY_IH:          whole = TOK_QUEST;
      KEY_IP | KEY_IR | KEY_VA | KEY_FF:          whole = TOK_NEWLINE;
      KEY_NUM | KEY_VO:                           whole = TOK_D0;
      KEY_NUM | KEY_IS:                           whole = TOK_D1;
      KEY_NUM | KEY_IT:                           whole = TOK_D2;
      KEY_NUM | KEY_IP:                           whole = TOK_D3;
      KEY_NUM | KEY_IH:                           whole = TOK_D4;
      KEY_NUM | KEY_VA:                           whole = TOK_D5;
      KEY_NUM | KEY_FF:                           whole = TOK_D6;
      KEY_NUM | KEY_FP:                           whole = TOK_D7;
      KEY_NUM | KEY_FL:                           whole = TOK_D8;
      KEY_NUM | KEY_FT:                           whole = TOK_D9;
      default:                                    whole = TOK_NONE;
    endcase
  end

  // initial-key combinations, star included
  assign init_bits = chord & MASK_INIT;
  always_comb begin
    unique case (init_bits)
      KEY_IP | KEY_IW:                            init_combo = TOK_B;
      KEY_IK | KEY_IH:                            init_combo = TOK_CH;
      KEY_IT | KEY_IK:                            init_combo = TOK_D;
      KEY_IT | KEY_IP:                            init_combo = TOK_F;
      KEY_IT | KEY_IK | KEY_IP | KEY_IW:          init_combo = TOK_G;
      KEY_IS | KEY_IK | KEY_IW | KEY_IR:          init_combo = TOK_J;
      KEY_IH | KEY_IR:                            init_combo = TOK_L;
      KEY_IP | KEY_IH:                            init_combo = TOK_M;
      KEY_IT | KEY_IP | KEY_IH:                   init_combo = TOK_N;
      KEY_IK | KEY_IW:                            init_combo = TOK_QU;
      KEY_IS | KEY_IR:                            init_combo = TOK_V;
      KEY_IK | KEY_IW | KEY_IR:                   init_combo = TOK_Y;
      KEY_IS | KEY_STAR:                          init_combo = TOK_Z;
      default:                                    init_combo = TOK_NONE;
    endcase
  end

  // vowel combinations
  assign vow_bits = chord & MASK_VOW;
  always_comb begin
    unique case (vow_bits)
      KEY_VA | KEY_VE | KEY_VU:                   vow_combo = TOK_AY;
      KEY_VA | KEY_VU:                            vow_combo = TOK_AW;
      KEY_VA | KEY_VO | KEY_VE:                   vow_combo = TOK_EE;
      KEY_VE | KEY_VU:                            vow_combo = TOK_I;
      KEY_VA | KEY_VO | KEY_VE | KEY_VU:          vow_combo = TOK_IY;
      KEY_VO | KEY_VE:                            vow_combo = TOK_OH;
      KEY_VO | KEY_VE | KEY_VU:                   vow_combo = TOK_OI;
      KEY_VA | KEY_VO:                            vow_combo = TOK_OO;
      KEY_VO | KEY_VU:                            vow_combo = TOK_OU;
      KEY_VA | KEY_VO | KEY_VU:                   vow_combo = TOK_UU;
      default:                                    vow_combo = TOK_NONE;
    endcase
  end

  // star survives the initials only when no initial combination took it
  assign star_left = chord[10] & (init_combo == TOK_NONE);

  // final combinations; star is always gone by now, either in the Z
  // combination or as the printed star, so the star patterns never hit
  assign fin_bits = chord & MASK_FIN & ~KEY_STAR;
  always_comb begin
    unique case (fin_bits)
      KEY_FF | KEY_FP:                            fin_combo = TOK_CH;
      KEY_FP | KEY_FB | KEY_FL | KEY_FG:          fin_combo = TOK_J;
      KEY_FB | KEY_FG:                            fin_combo = TOK_K;
      KEY_FP | KEY_FL:                            fin_combo = TOK_M;
      KEY_FF | KEY_FR | KEY_FP:                   fin_combo = TOK_MP;
      KEY_FP | KEY_FB:                            fin_combo = TOK_N;
      KEY_FP | KEY_FB | KEY_FG:                   fin_combo = TOK_NG;
      KEY_STAR | KEY_FP | KEY_FB | KEY_FG:        fin_combo = TOK_NK;
      KEY_FF | KEY_FR | KEY_FP | KEY_FB:          fin_combo = TOK_RCH;
      KEY_FF | KEY_FR | KEY_FB:                   fin_combo = TOK_RF;
      KEY_FR | KEY_FB:                            fin_combo = TOK_SH;
      KEY_STAR | KEY_FF:                          fin_combo = TOK_V;
      KEY_FB | KEY_FG | KEY_FS:                   fin_combo = TOK_X;
      KEY_FG | KEY_FS:                            fin_combo = TOK_SHUN;
      KEY_STAR | KEY_FB | KEY_FG | KEY_FS:        fin_combo = TOK_KSHUN;
      default:                                    fin_combo = TOK_NONE;
    endcase
  end

  // a whole-chord match consumes every key
  always_comb begin
    desc = '0;
    if (whole != TOK_NONE) begin
      desc.whole = whole;
    end else begin
      desc.whole      = TOK_NONE;
      desc.init_combo = init_combo;
      desc.init_keys  = (init_combo == TOK_NONE) ? chord[7:1] : 7'd0;
      desc.vow_combo  = vow_combo;
      desc.vow_keys   = (vow_combo == TOK_NONE)
                      ? {chord[12], chord[11], star_left, chord[9], chord[8]}
                      : {1'b0, 1'b0, star_left, 1'b0, 1'b0};
      desc.fin_combo  = fin_combo;
      desc.fin_keys   = (fin_combo == TOK_NONE) ? chord[22:13] : 10'd0;
    end
  end

endmodule

>>> hdl/sct_queue.sv
// Short descriptor queue between the front and back parts
module sct_queue import sct_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  sct_desc_t in_desc,
  output logic      out_valid,
  input  logic      out_pop,
  output sct_desc_t out_desc
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  sct_desc_t       store [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != CntW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid & in_ready;
  assign pop       = out_pop & out_valid;
  assign out_desc  = store[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= in_desc;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/sct_back.sv
// Back part: sends a chord's tokens one character per cycle while not stalled
module sct_back import sct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  output logic       q_pop,
  input  sct_desc_t  q_desc,
  output logic       m_valid,
  input  logic       m_ready,
  output logic [6:0] m_char,
  output logic       m_last,
  output logic       m_empty
);

  logic                 busy;
  sct_desc_t            desc;
  logic [NUM_SLOTS-1:0] pending;
  logic [NUM_SLOTS-1:0] pending_next;
  logic [NUM_SLOTS-1:0] lowbit;
  logic [NUM_SLOTS-1:0] rest;
  logic [3:0]           offset;
  logic [3:0]           rev;
  tok_t                 sid [NUM_SLOTS];
  tok_t                 tok;
  tok_info_t            info;
  logic [6:0]           ch;
  logic                 nothing;
  logic                 last_tok;
  logic                 done;
  logic                 adv;
  logic                 emit;

  // token of each slot
  always_comb begin
    sid[0]  = desc.whole;
    sid[1]  = desc.init_combo;
    sid[2]  = TOK_S;
    sid[3]  = TOK_T;
    sid[4]  = TOK_K;
    sid[5]  = TOK_P;
    sid[6]  = TOK_W;
    sid[7]  = TOK_H;
    sid[8]  = TOK_R;
    sid[9]  = desc.vow_combo;
    sid[10] = TOK_A;
    sid[11] = TOK_O;
    sid[12] = TOK_STAR;
    sid[13] = TOK_E;
    sid[14] = TOK_U;
    sid[15] = desc.fin_combo;
    sid[16] = TOK_F;
    sid[17] = TOK_R;
    sid[18] = TOK_P;
    sid[19] = TOK_B;
    sid[20] = TOK_L;
    sid[21] = TOK_G;
    sid[22] = TOK_T;
    sid[23] = TOK_S;
    sid[24] = TOK_D;
    sid[25] = TOK_Z;
  end

  // slots that carry text for a freshly loaded chord
  assign pending_next = {q_desc.fin_keys, q_desc.fin_combo != TOK_NONE,
                         q_desc.vow_keys, q_desc.vow_combo != TOK_NONE,
                         q_desc.init_keys, q_desc.init_combo != TOK_NONE,
                         q_desc.whole != TOK_NONE};

  // first pending slot and its current character
  assign lowbit = pending & (~pending + 1'b1);
  assign rest   = pending & ~lowbit;
  always_comb begin
    tok = TOK_NONE;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (lowbit[k]) begin
        tok = sid[k];
      end
    end
  end
  assign info     = tok_text(tok);
  assign rev      = info.len - 4'd1 - offset;
  assign ch       = info.text[{rev, 3'b000} +: 7];
  assign nothing  = (pending == '0);
  assign last_tok = (offset == info.len - 4'd1);
  assign done     = nothing | (last_tok & (rest == '0));

  // handshake control
  assign adv   = !m_valid || m_ready;
  assign emit  = busy & adv;
  assign q_pop = q_valid & (!busy | (emit & done));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      if (adv) begin
        m_valid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
      end else if (emit && done) begin
        busy <= 1'b0;
      end
    end
  end

  // chord being sent and position inside it
  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc    <= q_desc;
      pending <= pending_next;
      offset  <= 4'd0;
    end else if (emit) begin
      if (last_tok) begin
        pending <= rest;
        offset  <= 4'd0;
      end else begin
        offset <= offset + 4'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      m_char  <= nothing ? 7'd0 : ch;
      m_last  <= done;
      m_empty <= nothing;
    end
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the stenotype chord to text translator
`timescale 1ns / 100ps

module testbench;
  import sct_pkg::*;

  // chord to character stream, one beat per character
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic       empty;
  } text_beat_t;

  localparam logic [22:0] ALL_KEYS = 23'h7FFFFF;

  // rule table section boundaries, in firing order
  localparam int FIRST_INIT_COMBO = 16;
  localparam int FIRST_VOW_COMBO  = 36;
  localparam int FIRST_FIN_COMBO  = 51;
  localparam int FIRST_FIN_KEY    = 66;
  localparam int LAST_RULE        = 75;
  localparam int MAX_CHARS        = 22;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // chord [22:0], zero [23]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // text_char [6:0], zero [7]
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;        // empty_res [0]

  // replacement rules: a rule fires when (keys & mask) == pattern
  logic [22:0] rule_mask[$];
  logic [22:0] rule_pat[$];
  string       rule_txt[$];

  text_beat_t  pending_text[$];
  int          mismatch_count = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_stalls = 1'b1;
  int          stall_left = 0;

  steno_chord_to_text dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!rx_stalls) begin
      m_axis_tready <= 1'b1;
    end else begin : pick_ready
      int p;
      p = $urandom_range(0, 99);
      if (p < 4) begin
        stall_left    <= $urandom_range(10, 40);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (p >= 30);
      end
    end
  end

  // compare every output transaction with the oldest expected character
  always @(posedge clk) begin : text_check
    text_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_text.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected character: expected none actual %02h last %0b empty %0b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = pending_text.pop_front();
        if (m_axis_tdata !== {1'b0, want.ch}) begin
          mismatch_count++;
          $display("%0t text_char mismatch: expected %02h actual %02h",
                   $time, {1'b0, want.ch}, m_axis_tdata);
        end
        if (m_axis_tlast !== want.last) begin
          mismatch_count++;
          $display("%0t last mismatch: expected %0b actual %0b",
                   $time, want.last, m_axis_tlast);
        end
        if (m_axis_tuser !== want.empty) begin
          mismatch_count++;
          $display("%0t empty_res mismatch: expected %0b actual %0b",
                   $time, want.empty, m_axis_tuser);
        end
      end
    end
  end

  function automatic void add_rule(input logic [22:0] mask, input logic [22:0] pat,
                                   input string txt);
    rule_mask.push_back(mask);
    rule_pat.push_back(pat);
    rule_txt.push_back(txt);
  endfunction

  task automatic build_rule_table();
    // whole-chord punctuation, commands and digits
    add_rule(ALL_KEYS, KEY_FR | KEY_FB | KEY_FG | KEY_FS, ",");
    add_rule(ALL_KEYS, KEY_STAR, "[correction]");
    add_rule(ALL_KEYS, KEY_IP | KEY_FF, "[paragraph]");
    add_rule(ALL_KEYS, KEY_FF | KEY_FP | KEY_FL | KEY_FT, ".");
    add_rule(ALL_KEYS, KEY_IS | KEY_IT | KEY_IP | KEY_IH, "?");
    add_rule(ALL_KEYS, KEY_IP | KEY_IR | KEY_VA | KEY_FF, "[newline]");
    add_rule(ALL_KEYS, KEY_NUM | KEY_VO, "0");
    add_rule(ALL_KEYS, KEY_NUM | KEY_IS, "1");
    add_rule(ALL_KEYS, KEY_NUM | KEY_IT, "2");
    add_rule(ALL_KEYS, KEY_NUM | KEY_IP, "3");
    add_rule(ALL_KEYS, KEY_NUM | KEY_IH, "4");
    add_rule(ALL_KEYS, KEY_NUM | KEY_VA, "5");
    add_rule(ALL_KEYS, KEY_NUM | KEY_FF, "6");
    add_rule(ALL_KEYS, KEY_NUM | KEY_FP, "7");
    add_rule(ALL_KEYS, KEY_NUM | KEY_FL, "8");
    add_rule(ALL_KEYS, KEY_NUM | KEY_FT, "9");
    // initial combinations
    add_rule(MASK_INIT, KEY_IP | KEY_IW, "B");
    add_rule(MASK_INIT, KEY_IK | KEY_IH, "CH");
    add_rule(MASK_INIT, KEY_IT | KEY_IK, "D");
    add_rule(MASK_INIT, KEY_IT | KEY_IP, "F");
    add_rule(MASK_INIT, KEY_IT | KEY_IK | KEY_IP | KEY_IW, "G");
    add_rule(MASK_INIT, KEY_IS | KEY_IK | KEY_IW | KEY_IR, "J");
    add_rule(MASK_INIT, KEY_IH | KEY_IR, "L");
    add_rule(MASK_INIT, KEY_IP | KEY_IH, "M");
    add_rule(MASK_INIT, KEY_IT | KEY_IP | KEY_IH, "N");
    add_rule(MASK_INIT, KEY_IK | KEY_IW, "QU");
    add_rule(MASK_INIT, KEY_IS | KEY_IR, "V");
    add_rule(MASK_INIT, KEY_IK | KEY_IW | KEY_IR, "Y");
    add_rule(MASK_INIT, KEY_IS | KEY_STAR, "Z");
    // single initial keys
    add_rule(KEY_IS, KEY_IS, "S");
    add_rule(KEY_IT, KEY_IT, "T");
    add_rule(KEY_IK, KEY_IK, "K");
    add_rule(KEY_IP, KEY_IP, "P");
    add_rule(KEY_IW, KEY_IW, "W");
    add_rule(KEY_IH, KEY_IH, "H");
    add_rule(KEY_IR, KEY_IR, "R");
    // vowel combinations
    add_rule(MASK_VOW, KEY_VA | KEY_VE | KEY_VU, "AY");
    add_rule(MASK_VOW, KEY_VA | KEY_VU, "AW");
    add_rule(MASK_VOW, KEY_VA | KEY_VO | KEY_VE, "EE");
    add_rule(MASK_VOW, KEY_VE | KEY_VU, "I");
    add_rule(MASK_VOW, KEY_VA | KEY_VO | KEY_VE | KEY_VU, "IY");
    add_rule(MASK_VOW, KEY_VO | KEY_VE, "OH");
    add_rule(MASK_VOW, KEY_VO | KEY_VE | KEY_VU, "OI");
    add_rule(MASK_VOW, KEY_VA | KEY_VO, "OO");
    add_rule(MASK_VOW, KEY_VO | KEY_VU, "OU");
    add_rule(MASK_VOW, KEY_VA | KEY_VO | KEY_VU, "UU");
    // single vowels and star
    add_rule(KEY_VA, KEY_VA, "A");
    add_rule(KEY_VO, KEY_VO, "O");
    add_rule(KEY_STAR, KEY_STAR, "*");
    add_rule(KEY_VE, KEY_VE, "E");
    add_rule(KEY_VU, KEY_VU, "U");
    // final combinations, the star ones can never fire
    add_rule(MASK_FIN, KEY_FF | KEY_FP, "CH");
    add_rule(MASK_FIN, KEY_FP | KEY_FB | KEY_FL | KEY_FG, "J");
    add_rule(MASK_FIN, KEY_FB | KEY_FG, "K");
    add_rule(MASK_FIN, KEY_FP | KEY_FL, "M");
    add_rule(MASK_FIN, KEY_FF | KEY_FR | KEY_FP, "MP");
    add_rule(MASK_FIN, KEY_FP | KEY_FB, "N");
    add_rule(MASK_FIN, KEY_FP | KEY_FB | KEY_FG, "NG");
    add_rule(MASK_FIN, KEY_STAR | KEY_FP | KEY_FB | KEY_FG, "NK");
    add_rule(MASK_FIN, KEY_FF | KEY_FR | KEY_FP | KEY_FB, "RCH");
    add_rule(MASK_FIN, KEY_FF | KEY_FR | KEY_FB, "RF");
    add_rule(MASK_FIN, KEY_FR | KEY_FB, "SH");
    add_rule(MASK_FIN, KEY_STAR | KEY_FF, "V");
    add_rule(MASK_FIN, KEY_FB | KEY_FG | KEY_FS, "X");
    add_rule(MASK_FIN, KEY_FG | KEY_FS, "SHUN");
    add_rule(MASK_FIN, KEY_STAR | KEY_FB | KEY_FG | KEY_FS, "KSHUN");
    // single final keys
    add_rule(KEY_FF, KEY_FF, "F");
    add_rule(KEY_FR, KEY_FR, "R");
    add_rule(KEY_FP, KEY_FP, "P");
    add_rule(KEY_FB, KEY_FB, "B");
    add_rule(KEY_FL, KEY_FL, "L");
    add_rule(KEY_FG, KEY_FG, "G");
    add_rule(KEY_FT, KEY_FT, "T");
    add_rule(KEY_FS, KEY_FS, "S");
    add_rule(KEY_FD, KEY_FD, "D");
    add_rule(KEY_FZ, KEY_FZ, "Z");
  endtask

  // translate a chord and queue its characters
  function automatic void predict_text(input logic [22:0] chord);
    logic [22:0] keys;
    string       txt;
    int          n;
    text_beat_t  beat;
    keys = chord;
    txt  = "";
    for (int r = 0; r < rule_mask.size(); r++) begin
      if ((keys & rule_mask[r]) == rule_pat[r]) begin
        keys &= ~rule_mask[r];
        txt = {txt, rule_txt[r]};
      end
    end
    n = (txt.len() > MAX_CHARS) ? MAX_CHARS : txt.len();
    if (n == 0) begin
      beat.ch    = '0;
      beat.last  = 1'b1;
      beat.empty = 1'b1;
      pending_text.push_back(beat);
    end
    for (int i = 0; i < n; i++) begin
      beat.ch    = 7'(txt[i]);
      beat.last  = (i == n - 1);
      beat.empty = 1'b0;
      pending_text.push_back(beat);
    end
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (!tx_gaps || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // offer one chord and wait for the transaction
  task automatic send_chord(input logic [22:0] chord);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, chord};
    do @(posedge clk); while (!s_axis_tready);
    predict_text(chord);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
  endtask

  // every whole-chord punctuation, command and digit
  task automatic test_whole_chords();
    for (int r = 0; r < FIRST_INIT_COMBO; r++) send_chord(rule_pat[r]);
  endtask

  // empty translations, unreachable star finals, longest chord
  task automatic test_empty_and_star();
    send_chord('0);
    send_chord(KEY_NUM);
    send_chord(ALL_KEYS);
    send_chord(KEY_STAR | KEY_FP | KEY_FB | KEY_FG);
    send_chord(KEY_STAR | KEY_FF);
    send_chord(KEY_STAR | KEY_FB | KEY_FG | KEY_FS);
    send_chord(KEY_NUM | KEY_VO | KEY_VA);
  endtask

  // each group rule with random keys outside its mask, no idling
  task automatic test_rule_sweep();
    logic [22:0] extra;
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    for (int r = FIRST_INIT_COMBO; r <= LAST_RULE; r++) begin
      extra = 23'($urandom()) & ~rule_mask[r];
      send_chord(rule_pat[r] | extra);
    end
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    wait_drained();
  endtask

  // chords built from initial, vowel and final rule patterns
  task automatic test_shaped_chords(input int count);
    logic [22:0] chord;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        tx_gaps   = ($urandom_range(0, 3) != 0);
        rx_stalls = ($urandom_range(0, 3) != 0);
      end
      chord = '0;
      if ($urandom_range(0, 3) != 0)
        chord |= rule_pat[$urandom_range(FIRST_INIT_COMBO, FIRST_VOW_COMBO - 1)];
      if ($urandom_range(0, 3) != 0)
        chord |= rule_pat[$urandom_range(FIRST_VOW_COMBO, FIRST_FIN_COMBO - 1)];
      if ($urandom_range(0, 3) != 0)
        chord |= rule_pat[$urandom_range(FIRST_FIN_COMBO, LAST_RULE)];
      if ($urandom_range(0, 3) == 0)
        chord |= rule_pat[$urandom_range(FIRST_FIN_KEY, LAST_RULE)];
      if ($urandom_range(0, 9) == 0)
        chord ^= 23'(1) << $urandom_range(0, 22);
      if ($urandom_range(0, 11) == 0)
        chord = rule_pat[$urandom_range(0, FIRST_INIT_COMBO - 1)];
      send_chord(chord);
    end
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // whole-chord patterns with one key flipped
  task automatic test_near_misses(input int count);
    for (int i = 0; i < count; i++)
      send_chord(rule_pat[$urandom_range(0, FIRST_INIT_COMBO - 1)]
                 ^ (23'(1) << $urandom_range(0, 22)));
  endtask

  // unstructured chords over the full key range
  task automatic test_raw_chords(input int count);
    for (int i = 0; i < count; i++) send_chord(23'($urandom()));
  endtask

  initial begin
    build_rule_table();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_whole_chords();
    test_empty_and_star();
    test_rule_sweep();
    test_shaped_chords(200);
    test_near_misses(20);
    test_raw_chords(80);
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_text.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run time limit
  initial begin
    #(12_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> files.f
hdl/sct_pkg.sv
hdl/sct_front.sv
hdl/sct_queue.sv
hdl/sct_back.sv
hdl/steno_chord_to_text.sv
dv/testbench.sv
